// ===== src/ils_pkg.sv =====
// Shared types, constants and codes for the indexed list store.
package ils_pkg;

	localparam int DEPTH = 32;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 6;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int VAL_W = 32;

	typedef logic signed [VAL_W-1:0] elem_t;

	typedef enum logic [2:0] {
		OP_GET    = 3'd0,
		OP_HEAD   = 3'd1,
		OP_TAIL   = 3'd2,
		OP_INDEX  = 3'd3,
		OP_DELETE = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} st_t;

	localparam elem_t MISS_VALUE = '1;

	typedef struct packed {
		logic [2:0]       opcode;
		logic [POS_W-1:0] position;
		elem_t            item_value;
	} req_t;

	typedef struct packed {
		elem_t      read_value;
		logic [1:0] status;
		logic [5:0] count_now;
	} rsp_t;

	// Shift command broadcast to every cell of the chain.
	typedef struct packed {
		logic             ins;
		logic             del;
		logic [CMP_W-1:0] pos;
		elem_t            value;
	} cell_ctl_t;

endpackage

// ===== src/ils_cell.sv =====
// One storage cell of the list chain: holds one element and shifts with its neighbours.
module ils_cell (
	input  logic                    clk,
	input  ils_pkg::cell_ctl_t      ctl,
	input  logic [ils_pkg::CMP_W-1:0] idx,
	input  ils_pkg::elem_t          left_val,
	input  ils_pkg::elem_t          right_val,
	output ils_pkg::elem_t          cell_val
);

	ils_pkg::elem_t val_q;
	ils_pkg::elem_t val_nxt;

	// On insert the cells above the position take their lower neighbour and the
	// cell at the position takes the new value; on delete the cells at and above
	// the position take their upper neighbour.
	always_comb begin
		val_nxt = val_q;
		if (ctl.ins) begin
			if (idx > ctl.pos) begin
				val_nxt = left_val;
			end else if (idx == ctl.pos) begin
				val_nxt = ctl.value;
			end
		end else if (ctl.del) begin
			if (idx >= ctl.pos) begin
				val_nxt = right_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_nxt;
	end

	assign cell_val = val_q;

endmodule

// ===== src/ils_chain.sv =====
// Row of list cells with neighbour links and the read select for get requests.
module ils_chain (
	input  logic               clk,
	input  ils_pkg::cell_ctl_t ctl,
	output ils_pkg::elem_t     rd_data
);

	ils_pkg::elem_t vals [ils_pkg::DEPTH];

	for (genvar i = 0; i < ils_pkg::DEPTH; i++) begin : g_cell
		ils_pkg::elem_t left_val;
		ils_pkg::elem_t right_val;

		if (i == 0) begin : g_first
			assign left_val = '0;
		end else begin : g_inner_l
			assign left_val = vals[i-1];
		end

		if (i == ils_pkg::DEPTH - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_inner_r
			assign right_val = vals[i+1];
		end

		ils_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.idx       (ils_pkg::CMP_W'(i)),
			.left_val  (left_val),
			.right_val (right_val),
			.cell_val  (vals[i])
		);
	end

	// The caller only uses this when the position is below the count.
	assign rd_data = vals[ctl.pos[ils_pkg::IDX_W-1:0]];

endmodule

// ===== src/indexed_list_store.sv =====
// Top level of the indexed list store: request decode, element count and result buffering.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+---------------------------------------
//   req     | in        | req_valid / req_stall | ils_pkg::req_t (opcode, position, value)
//   rsp     | out       | rsp_valid / rsp_stall | ils_pkg::rsp_t (value, status, count)
//
// The whole row of cells shifts in parallel, so one transaction can be accepted per cycle
// while req_stall is low; its result is registered in the output or the skid register.
// Reset clears the count and the result buffers; cells at or above the count are never
// read, so their contents are left as they are.
// An output register plus a skid register hold waiting results; req_stall rises only
// when both are full.
module indexed_list_store (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ils_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ils_pkg::rsp_t  rsp
);

	logic [ils_pkg::CNT_W-1:0] count_q;
	logic [ils_pkg::CNT_W-1:0] count_nxt;

	ils_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;
	ils_pkg::rsp_t skid_q;
	logic          skid_valid_q;

	ils_pkg::cell_ctl_t ctl;
	ils_pkg::elem_t     rd_data;
	ils_pkg::rsp_t      rsp_new;

	logic                      acc;
	logic                      out_leave;
	logic                      full;
	logic [ils_pkg::CMP_W-1:0] pos_ext;
	logic [ils_pkg::CMP_W-1:0] cnt_ext;
	logic                      want_ins;
	logic                      want_del;
	logic [ils_pkg::CMP_W-1:0] ins_pos;
	ils_pkg::elem_t            rd_val;
	ils_pkg::st_t              st;

	// Input is held off only when the skid register is occupied.
	assign req_stall = skid_valid_q;
	assign acc       = req_valid && !skid_valid_q;
	assign out_leave = rsp_valid_q && !rsp_stall;

	assign full    = (count_q == ils_pkg::CNT_W'(ils_pkg::DEPTH));
	assign pos_ext = ils_pkg::CMP_W'(req.position);
	assign cnt_ext = ils_pkg::CMP_W'(count_q);

	// Request decode. The range check of an insert at a position comes before
	// the full check, and a delete or get from an empty store is out of range.
	always_comb begin
		want_ins = 1'b0;
		want_del = 1'b0;
		ins_pos  = pos_ext;
		rd_val   = ils_pkg::MISS_VALUE;
		st       = ils_pkg::ST_DONE;
		case (req.opcode)
			ils_pkg::OP_GET: begin
				if (pos_ext < cnt_ext) begin
					rd_val = rd_data;
				end else begin
					st = ils_pkg::ST_RANGE;
				end
			end
			ils_pkg::OP_HEAD: begin
				ins_pos = '0;
				if (full) begin
					st = ils_pkg::ST_FULL;
				end else begin
					want_ins = 1'b1;
				end
			end
			ils_pkg::OP_TAIL: begin
				ins_pos = cnt_ext;
				if (full) begin
					st = ils_pkg::ST_FULL;
				end else begin
					want_ins = 1'b1;
				end
			end
			ils_pkg::OP_INDEX: begin
				if (pos_ext > cnt_ext) begin
					st = ils_pkg::ST_RANGE;
				end else if (full) begin
					st = ils_pkg::ST_FULL;
				end else begin
					want_ins = 1'b1;
				end
			end
			ils_pkg::OP_DELETE: begin
				if (pos_ext < cnt_ext) begin
					want_del = 1'b1;
				end else begin
					st = ils_pkg::ST_RANGE;
				end
			end
			default: begin
				st = ils_pkg::ST_RANGE;
			end
		endcase
	end

	// The chain only moves for an accepted transaction.
	always_comb begin
		ctl.ins   = acc && want_ins;
		ctl.del   = acc && want_del;
		ctl.pos   = ins_pos;
		ctl.value = req.item_value;
	end

	always_comb begin
		count_nxt = count_q;
		if (ctl.ins) begin
			count_nxt = count_q + 1'b1;
		end else if (ctl.del) begin
			count_nxt = count_q - 1'b1;
		end
	end

	always_comb begin
		rsp_new.read_value = rd_val;
		rsp_new.status     = st;
		rsp_new.count_now  = 6'(count_nxt);
	end

	ils_chain u_chain (
		.clk     (clk),
		.ctl     (ctl),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// Result buffer control. When the output register drains, the skid entry
	// moves up first; a fresh result goes to the output register if that is
	// free, otherwise it is parked in the skid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_leave) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					rsp_valid_q <= acc;
				end
			end else if (acc) begin
				if (rsp_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					rsp_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_leave) begin
			if (skid_valid_q) begin
				rsp_q <= skid_q;
			end else if (acc) begin
				rsp_q <= rsp_new;
			end
		end else if (acc) begin
			if (rsp_valid_q) begin
				skid_q <= rsp_new;
			end else begin
				rsp_q <= rsp_new;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
